// ===== design/biquad_bandpass_filter_macros.svh =====
// assertion macros for the band-pass biquad block
// no dependencies; taken in by the files that carry assertions
`ifndef BIQUAD_BANDPASS_FILTER_MACROS_SVH
`define BIQUAD_BANDPASS_FILTER_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define BQBPF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define BQBPF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/bqbpf_pkg.sv =====
// shared types and constants for the band-pass biquad block
// no dependencies; used by bqbpf_digit_mul and biquad_bandpass_filter
package bqbpf_pkg;

   localparam int SAMPLE_WIDTH = 24;
   localparam int COEF_WIDTH = 24;
   localparam int DIGIT_WIDTH_DEF = 4;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FB_COEF_ONE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FB_COEF_TWO = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BAND_GAIN = 2'd2;

   typedef struct packed {
      logic                    block_start;
      logic [SAMPLE_WIDTH-1:0] sample_in;
   } req_data_type;

   typedef struct packed {
      logic [SAMPLE_WIDTH-1:0] sample_out;
      logic                    clipped;
   } rsp_data_type;

   typedef struct packed {
      logic load;
      logic step;
   } mul_ctrl_type;

endpackage

// ===== design/bqbpf_digit_mul.sv =====
// digit-serial unsigned multiplier: one multiplier digit per cycle while step is set, lsb first
// depends on bqbpf_pkg (mul_ctrl_type)
module bqbpf_digit_mul import bqbpf_pkg::*; #(
   parameter int MAG_WIDTH = SAMPLE_WIDTH + 2,
   parameter int MUL_WIDTH = COEF_WIDTH,
   parameter int DIGIT_WIDTH = DIGIT_WIDTH_DEF
) (
   input  logic                           clock,
   input  mul_ctrl_type                   ctrl,
   input  logic [MAG_WIDTH-1:0]           mcand,
   input  logic [MUL_WIDTH-1:0]           mplier,
   output logic [MAG_WIDTH+MUL_WIDTH-1:0] product
);

   localparam int NUM_DIGITS = (MUL_WIDTH + DIGIT_WIDTH - 1) / DIGIT_WIDTH;
   localparam int Q_WIDTH = NUM_DIGITS * DIGIT_WIDTH;
   localparam int ADD_WIDTH = MAG_WIDTH + DIGIT_WIDTH;

   logic [MAG_WIDTH-1:0] mcand_ff, mcand_in;
   logic [MAG_WIDTH-1:0] acc_ff, acc_in;
   logic [Q_WIDTH-1:0]   mq_ff, mq_in;
   logic [ADD_WIDTH-1:0] partial;
   logic [ADD_WIDTH-1:0] acc_sum;
   logic [MAG_WIDTH+Q_WIDTH-1:0] full;

   always_comb begin
      partial = '0;
      for (int i = 0; i < DIGIT_WIDTH; i++) begin
         if (mq_ff[i]) begin
            partial = partial + (ADD_WIDTH'(mcand_ff) << i);
         end
      end
      acc_sum = ADD_WIDTH'(acc_ff) + partial;
   end

   always_comb begin
      mcand_in = mcand_ff;
      acc_in = acc_ff;
      mq_in = mq_ff;
      if (ctrl.load) begin
         mcand_in = mcand;
         acc_in = '0;
         mq_in = Q_WIDTH'(mplier);
      end else if (ctrl.step) begin
         // product low bits move in where consumed multiplier digits leave
         acc_in = acc_sum[ADD_WIDTH-1:DIGIT_WIDTH];
         mq_in = {acc_sum[DIGIT_WIDTH-1:0], mq_ff[Q_WIDTH-1:DIGIT_WIDTH]};
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      acc_ff <= acc_in;
      mq_ff <= mq_in;
   end

   assign full = {acc_ff, mq_ff};
   assign product = full[MAG_WIDTH+MUL_WIDTH-1:0];

endmodule

// ===== design/biquad_bandpass_filter.sv =====
// Band-pass biquad for one equalizer band: y = G*(x - x[n-2] - a1*y[n-1] - a2*y[n-2]),
// products rounded to nearest (ties away from zero), output saturated with a clip flag.
// An item goes through two digit-serial multiplier passes: the two feedback products
// run side by side, then the gain product reuses one unit. No new item is accepted
// until the last one has been placed in the output register, where it waits while the
// next item is accepted. DIGIT_WIDTH may be 1 to 8. The user must write coefficients
// through the csr port only while no item is in flight; the block does not enforce it.
// Depends on bqbpf_pkg, bqbpf_digit_mul and biquad_bandpass_filter_macros.svh.
`include "biquad_bandpass_filter_macros.svh"

module biquad_bandpass_filter import bqbpf_pkg::*; #(
   parameter int DIGIT_WIDTH = DIGIT_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_data_type               req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_data_type               rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COEF_WIDTH-1:0]      csr_data
);

   localparam int SW = SAMPLE_WIDTH;
   localparam int CW = COEF_WIDTH;
   localparam int MAG_WIDTH = SW + 2;
   localparam int SUM_WIDTH = SW + 3;
   localparam int PROD_WIDTH = MAG_WIDTH + CW;
   localparam int FB_SHIFT = CW - 2;
   localparam int GAIN_SHIFT = CW - 8;
   localparam int FB_RND_WIDTH = PROD_WIDTH - FB_SHIFT;
   localparam int GAIN_RND_WIDTH = PROD_WIDTH - GAIN_SHIFT + 1;
   localparam int NUM_DIGITS = (CW + DIGIT_WIDTH - 1) / DIGIT_WIDTH;
   localparam int COUNT_WIDTH = $clog2(NUM_DIGITS);
   localparam logic [COUNT_WIDTH-1:0] COUNT_LAST = COUNT_WIDTH'(NUM_DIGITS - 1);
   localparam logic [GAIN_RND_WIDTH-1:0] SAT_MAG = GAIN_RND_WIDTH'(1) << (SW - 1);
   localparam logic [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
   localparam logic [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
   localparam logic [CW-1:0] GAIN_RESET = CW'(1) << (CW - 8);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL1 = 3'd1;
   localparam logic [2:0] ST_SUM  = 3'd2;
   localparam logic [2:0] ST_MUL2 = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [CW-1:0]          a1_ff, a1_in, a2_ff, a2_in, gain_ff, gain_in;
   logic [SW-1:0]          x_ff, x_in;
   logic [SW-1:0]          xd1_ff, xd1_in, xd2_ff, xd2_in;
   logic [SW-1:0]          yd1_ff, yd1_in, yd2_ff, yd2_in;
   logic                   neg_a_ff, neg_a_in, neg_b_ff, neg_b_in, neg_sum_ff, neg_sum_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_data_type           rsp_data_ff, rsp_data_in;

   mul_ctrl_type           ctrl_a, ctrl_b;
   logic [MAG_WIDTH-1:0]   mcand_a, mcand_b;
   logic [CW-1:0]          mplier_a, mplier_b;
   logic [PROD_WIDTH-1:0]  prod_a, prod_b;

   logic                   req_accept, out_free;
   logic [SW-1:0]          y1_eff, y2_eff, y1_mag, y2_mag;
   logic [CW-1:0]          a1_mag, a2_mag;
   logic [FB_RND_WIDTH-1:0]   r1, r2;
   logic [SUM_WIDTH-1:0]   t1, t2, sum, sum_mag;
   logic [GAIN_RND_WIDTH-1:0] rg;
   logic                   clip_pos, clip_neg;
   logic [SW-1:0]          y_val;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   bqbpf_digit_mul #(
      .MAG_WIDTH(MAG_WIDTH),
      .MUL_WIDTH(CW),
      .DIGIT_WIDTH(DIGIT_WIDTH)
   ) u_mul_a (
      .clock(clock),
      .ctrl(ctrl_a),
      .mcand(mcand_a),
      .mplier(mplier_a),
      .product(prod_a)
   );

   bqbpf_digit_mul #(
      .MAG_WIDTH(MAG_WIDTH),
      .MUL_WIDTH(CW),
      .DIGIT_WIDTH(DIGIT_WIDTH)
   ) u_mul_b (
      .clock(clock),
      .ctrl(ctrl_b),
      .mcand(mcand_b),
      .mplier(mplier_b),
      .product(prod_b)
   );

   // sign-magnitude operands for the feedback products
   always_comb begin
      y1_eff = req_data.block_start ? '0 : yd1_ff;
      y2_eff = req_data.block_start ? '0 : yd2_ff;
      y1_mag = y1_eff[SW-1] ? -y1_eff : y1_eff;
      y2_mag = y2_eff[SW-1] ? -y2_eff : y2_eff;
      a1_mag = a1_ff[CW-1] ? -a1_ff : a1_ff;
      a2_mag = a2_ff[CW-1] ? -a2_ff : a2_ff;
   end

   // feedback terms rounded, then the exact four-term sum
   always_comb begin
      r1 = prod_a[PROD_WIDTH-1:FB_SHIFT] + FB_RND_WIDTH'(prod_a[FB_SHIFT-1]);
      r2 = prod_b[PROD_WIDTH-1:FB_SHIFT] + FB_RND_WIDTH'(prod_b[FB_SHIFT-1]);
      t1 = neg_a_ff ? r1[SUM_WIDTH-1:0] : -r1[SUM_WIDTH-1:0];
      t2 = neg_b_ff ? r2[SUM_WIDTH-1:0] : -r2[SUM_WIDTH-1:0];
      sum = {{3{x_ff[SW-1]}}, x_ff} - {{3{xd2_ff[SW-1]}}, xd2_ff} + t1 + t2;
      sum_mag = sum[SUM_WIDTH-1] ? -sum : sum;
   end

   // gain product rounded and saturated
   always_comb begin
      rg = {1'b0, prod_a[PROD_WIDTH-1:GAIN_SHIFT]} + GAIN_RND_WIDTH'(prod_a[GAIN_SHIFT-1]);
      clip_pos = !neg_sum_ff && (rg >= SAT_MAG);
      clip_neg = neg_sum_ff && (rg > SAT_MAG);
      if (clip_pos) begin
         y_val = SAMPLE_MAX;
      end else if (clip_neg) begin
         y_val = SAMPLE_MIN;
      end else if (neg_sum_ff) begin
         y_val = -rg[SW-1:0];
      end else begin
         y_val = rg[SW-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      a1_in = a1_ff;
      a2_in = a2_ff;
      gain_in = gain_ff;
      x_in = x_ff;
      xd1_in = xd1_ff;
      xd2_in = xd2_ff;
      yd1_in = yd1_ff;
      yd2_in = yd2_ff;
      neg_a_in = neg_a_ff;
      neg_b_in = neg_b_ff;
      neg_sum_in = neg_sum_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      ctrl_a = '0;
      ctrl_b = '0;
      mcand_a = MAG_WIDTH'(y1_mag);
      mplier_a = a1_mag;
      mcand_b = MAG_WIDTH'(y2_mag);
      mplier_b = a2_mag;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FB_COEF_ONE: a1_in = csr_data;
            CSR_FB_COEF_TWO: a2_in = csr_data;
            CSR_BAND_GAIN:   gain_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               x_in = req_data.sample_in;
               if (req_data.block_start) begin
                  xd1_in = '0;
                  xd2_in = '0;
                  yd1_in = '0;
                  yd2_in = '0;
               end
               neg_a_in = y1_eff[SW-1] ^ a1_ff[CW-1];
               neg_b_in = y2_eff[SW-1] ^ a2_ff[CW-1];
               ctrl_a.load = 1'b1;
               ctrl_b.load = 1'b1;
               count_in = COUNT_LAST;
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            ctrl_a.step = 1'b1;
            ctrl_b.step = 1'b1;
            count_in = count_ff - 1'b1;
            if (count_ff == '0) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            mcand_a = sum_mag[MAG_WIDTH-1:0];
            mplier_a = gain_ff;
            ctrl_a.load = 1'b1;
            neg_sum_in = sum[SUM_WIDTH-1];
            count_in = COUNT_LAST;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            ctrl_a.step = 1'b1;
            count_in = count_ff - 1'b1;
            if (count_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.sample_out = y_val;
               rsp_data_in.clipped = clip_pos || clip_neg;
               xd2_in = xd1_ff;
               xd1_in = x_ff;
               yd2_in = yd1_ff;
               yd1_in = y_val;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         a1_ff <= '0;
         a2_ff <= '0;
         gain_ff <= GAIN_RESET;
         xd1_ff <= '0;
         xd2_ff <= '0;
         yd1_ff <= '0;
         yd2_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         a1_ff <= a1_in;
         a2_ff <= a2_in;
         gain_ff <= gain_in;
         xd1_ff <= xd1_in;
         xd2_ff <= xd2_in;
         yd1_ff <= yd1_in;
         yd2_ff <= yd2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      neg_a_ff <= neg_a_in;
      neg_b_ff <= neg_b_in;
      neg_sum_ff <= neg_sum_in;
      rsp_data_ff <= rsp_data_in;
   end

   `BQBPF_ASSERT_NEXT(a_accept_starts_mul, clock, reset, req_accept, state_ff == ST_MUL1, "accepted item did not start the feedback products")
   `BQBPF_ASSERT_NEXT(a_mul1_to_sum, clock, reset, (state_ff == ST_MUL1) && (count_ff == '0), state_ff == ST_SUM, "feedback products did not end after the last digit")
   `BQBPF_ASSERT_NEXT(a_sum_to_mul2, clock, reset, state_ff == ST_SUM, (state_ff == ST_MUL2) && (count_ff == COUNT_LAST), "gain product did not start after the sum")
   `BQBPF_ASSERT_NEXT(a_done_delivers, clock, reset, (state_ff == ST_DONE) && out_free, rsp_valid_ff && (state_ff == ST_IDLE), "finished item not placed in the output register")
   `BQBPF_ASSERT_NOW(a_clip_at_limit, clock, reset, rsp_valid_ff && rsp_data_ff.clipped, (rsp_data_ff.sample_out == SAMPLE_MAX) || (rsp_data_ff.sample_out == SAMPLE_MIN), "clipped item not at a range limit")

endmodule
